### hw/rtl/obm_pkg.sv
// obm_pkg: shared types, codes and defaults of the order book matcher.
// Used by obm_scan and order_book_matcher under hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package obm_pkg;

    localparam int ORDER_SLOTS_DEF = 64;

    // commands
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_MODIFY = 2'd2;
    localparam logic [1:0] CMD_EOD    = 2'd3;

    // order types
    localparam logic [1:0] OT_GTC = 2'd0;
    localparam logic [1:0] OT_FAK = 2'd1;
    localparam logic [1:0] OT_GFD = 2'd2;
    localparam logic [1:0] OT_MKT = 2'd3;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam logic KIND_TRADE = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    // completion status
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_UNKNOWN  = 3'd2;
    localparam logic [2:0] ST_NOLIQ    = 3'd3;
    localparam logic [2:0] ST_NOTMKT   = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    typedef struct packed {
        logic [63:0]        id;
        logic               side;
        logic signed [31:0] price;
        logic [31:0]        rem;
        logic [1:0]         kind;
        logic [31:0]        arrival;
    } t_slot;

    typedef struct packed {
        logic [63:0]        bid_id;
        logic [63:0]        ask_id;
        logic signed [31:0] bid_price;
        logic signed [31:0] ask_price;
        logic [31:0]        qty;
    } t_trade;

    // scan results, indexed by side where paired
    typedef struct packed {
        logic              hit;
        logic [1:0]        hit_kind;
        logic              free_hit;
        logic [1:0]        w_any;
        logic [1:0][31:0]  w_price;
        logic [1:0]        b_any;
        t_slot [1:0]       best;
    } t_scan_res;

endpackage

### hw/rtl/obm_ram.sv
// obm_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`timescale 1ns / 1ps

module obm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/obm_scan.sv
// obm_scan: accumulates id lookup, free slot, worst and best price per side
// over one pass of slot reads. Depends on obm_pkg.
`timescale 1ns / 1ps

module obm_scan #(
    parameter int ORDER_SLOTS = obm_pkg::ORDER_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_dv,
    input  logic [$clog2(ORDER_SLOTS)-1:0] i_idx,
    input  obm_pkg::t_slot                 i_slot,
    input  logic                           i_slot_valid,
    input  logic [31:0]                    i_arrival,
    input  logic [63:0]                    i_id,
    output obm_pkg::t_scan_res             o_res,
    output logic [$clog2(ORDER_SLOTS)-1:0] o_hit_idx,
    output logic [$clog2(ORDER_SLOTS)-1:0] o_free_idx,
    output logic [$clog2(ORDER_SLOTS)-1:0] o_bid_idx,
    output logic [$clog2(ORDER_SLOTS)-1:0] o_ask_idx
);
    import obm_pkg::*;

    localparam int IW = $clog2(ORDER_SLOTS);

    t_scan_res       r_res, n_res, prev;
    logic [IW-1:0]   r_hit_idx, r_free_idx, n_hit_idx, n_free_idx;
    logic [1:0][IW-1:0] r_bidx, n_bidx;
    logic            sd;
    logic            better;
    logic [31:0]     age_new, age_best;

    always_comb begin
        prev = r_res;
        if (i_idx == '0) begin
            prev = '0;
        end
        n_res      = prev;
        n_hit_idx  = r_hit_idx;
        n_free_idx = r_free_idx;
        n_bidx     = r_bidx;
        sd         = i_slot.side;
        age_new    = i_arrival - i_slot.arrival;
        age_best   = i_arrival - prev.best[sd].arrival;

        if (!prev.hit && i_slot_valid && i_slot.id == i_id) begin
            n_res.hit      = 1'b1;
            n_res.hit_kind = i_slot.kind;
            n_hit_idx      = i_idx;
        end
        if (!prev.free_hit && !i_slot_valid) begin
            n_res.free_hit = 1'b1;
            n_free_idx     = i_idx;
        end
        if (i_slot_valid && (!prev.w_any[sd] ||
                (sd == SIDE_BUY ? i_slot.price < $signed(prev.w_price[sd])
                                : i_slot.price > $signed(prev.w_price[sd])))) begin
            n_res.w_any[sd]   = 1'b1;
            n_res.w_price[sd] = i_slot.price;
        end
        if (i_slot.price != prev.best[sd].price) begin
            better = sd == SIDE_BUY ? i_slot.price > prev.best[sd].price
                                    : i_slot.price < prev.best[sd].price;
        end else begin
            better = age_new > age_best;
        end
        if (i_slot_valid && (!prev.b_any[sd] || better)) begin
            n_res.b_any[sd] = 1'b1;
            n_res.best[sd]  = i_slot;
            n_bidx[sd]      = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dv) begin
            r_res      <= n_res;
            r_hit_idx  <= n_hit_idx;
            r_free_idx <= n_free_idx;
            r_bidx     <= n_bidx;
        end
    end

    assign o_res      = r_res;
    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;
    assign o_bid_idx  = r_bidx[0];
    assign o_ask_idx  = r_bidx[1];

endmodule

### hw/rtl/order_book_matcher.sv
// order_book_matcher: price-time-priority limit order book over a slot RAM.
// Depends on obm_pkg, obm_ram and obm_scan.
// Passes: cancel and end of day take one pass over the slot RAM, an accepted add two,
// an accepted modify three; each fill adds two writes and a pass.
// Results leave by a trade buffer read, then a load into the output register.
// Commands are taken one at a time; o_stall is high until the last result is loaded.
// Reset: i_rst_n synchronous, clears slot valid bits, counts and handshake.
`timescale 1ns / 1ps

module order_book_matcher #(
    parameter int ORDER_SLOTS = obm_pkg::ORDER_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic [63:0]        i_order_id,
    input  logic               i_side,
    input  logic signed [31:0] i_price,
    input  logic [31:0]        i_quantity,
    input  logic [1:0]         i_order_type,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic [2:0]         o_status,
    output logic [63:0]        o_bid_order_id,
    output logic [63:0]        o_ask_order_id,
    output logic signed [31:0] o_bid_price,
    output logic signed [31:0] o_ask_price,
    output logic [31:0]        o_trade_quantity,
    output logic [6:0]         o_resting_orders,
    output logic               o_last
);
    import obm_pkg::*;

    localparam int IW = $clog2(ORDER_SLOTS);
    localparam int CW = $clog2(ORDER_SLOTS + 1);

    // Sequencer: every command starts with a scan pass over all slots. The
    // pass result is judged in S_DECIDE; matching loops scan, decide, write.
    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_ADD_WR, S_MATCH_W1, S_MATCH_W2,
        S_EMIT_RD, S_EMIT_LD, S_EMIT_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_FIND, PH_ADD, PH_MATCH
    } t_phase;

    t_state              r_state;
    t_phase              r_phase;
    logic [1:0]          r_cmd;
    logic [63:0]         r_id;
    logic                r_side;
    logic signed [31:0]  r_price;
    logic [31:0]         r_qty;
    logic [1:0]          r_type;
    logic [2:0]          r_status;
    logic [CW-1:0]       r_cnt;
    logic                r_dv;
    logic [IW-1:0]       r_idx;
    logic [ORDER_SLOTS-1:0] r_valid;
    logic [6:0]          r_resting;
    logic [31:0]         r_arrival;
    logic [IW-1:0]       r_new_idx;
    logic [31:0]         r_q;
    logic [CW-1:0]       r_ntr;
    logic [CW-1:0]       r_k;

    // output register
    logic                r_o_valid, r_o_kind, r_o_last;
    logic [2:0]          r_o_status;
    t_trade              r_o_tr;
    logic [6:0]          r_o_resting;

    // slot RAM and trade buffer ports
    logic                slot_we, slot_re;
    logic [IW-1:0]       slot_waddr, slot_raddr;
    t_slot               slot_wdata, slot_rdata;
    logic                tr_we, tr_re;
    t_trade              tr_wdata, tr_rdata;

    t_scan_res           sres;
    logic [IW-1:0]       hit_idx, free_idx, bid_idx, ask_idx;

    // valid bit update request, at most one per cycle
    logic                n_vset, n_vclr;
    logic [IW-1:0]       n_vidx;

    logic                opp, cross_ok, book_cross, out_free, out_load;
    logic signed [31:0]  eff_price;
    logic [1:0]          eff_type;
    logic [31:0]         bid_rem, ask_rem;

    obm_ram #(.WIDTH($bits(t_slot)), .DEPTH(ORDER_SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    obm_ram #(.WIDTH($bits(t_trade)), .DEPTH(ORDER_SLOTS)) u_trade_ram (
        .i_clk   (i_clk),
        .i_we    (tr_we),
        .i_waddr (r_ntr[IW-1:0]),
        .i_wdata (tr_wdata),
        .i_re    (tr_re),
        .i_raddr (r_k[IW-1:0]),
        .o_rdata (tr_rdata)
    );

    obm_scan #(.ORDER_SLOTS(ORDER_SLOTS)) u_scan (
        .i_clk        (i_clk),
        .i_dv         (r_dv),
        .i_idx        (r_idx),
        .i_slot       (slot_rdata),
        .i_slot_valid (r_valid[r_idx]),
        .i_arrival    (r_arrival),
        .i_id         (r_id),
        .o_res        (sres),
        .o_hit_idx    (hit_idx),
        .o_free_idx   (free_idx),
        .o_bid_idx    (bid_idx),
        .o_ask_idx    (ask_idx)
    );

    assign out_free = !r_o_valid || !i_stall;
    // a result is loaded into the output register this cycle
    assign out_load = out_free && (r_state == S_EMIT_LD || r_state == S_EMIT_DONE);

    // add checks: a market order takes the worst opposite price
    always_comb begin
        opp       = ~r_side;
        eff_price = (r_type == OT_MKT) ? $signed(sres.w_price[opp]) : r_price;
        eff_type  = (r_type == OT_MKT) ? OT_GTC : r_type;
        cross_ok  = sres.b_any[opp] &&
                    (r_side == SIDE_BUY ? eff_price >= sres.best[opp].price
                                        : eff_price <= sres.best[opp].price);
        book_cross = sres.b_any[0] && sres.b_any[1] &&
                     sres.best[0].price >= sres.best[1].price;
        bid_rem   = sres.best[0].rem - r_q;
        ask_rem   = sres.best[1].rem - r_q;
    end

    // memory ports
    always_comb begin
        slot_re    = (r_state == S_SCAN) && (r_cnt < CW'(ORDER_SLOTS));
        slot_raddr = r_cnt[IW-1:0];
        slot_we    = 1'b0;
        slot_waddr = r_new_idx;
        slot_wdata = sres.best[0];
        tr_we      = 1'b0;
        tr_re      = (r_state == S_EMIT_RD) && (r_k < r_ntr);
        tr_wdata.bid_id    = sres.best[0].id;
        tr_wdata.ask_id    = sres.best[1].id;
        tr_wdata.bid_price = sres.best[0].price;
        tr_wdata.ask_price = sres.best[1].price;
        tr_wdata.qty       = r_q;
        unique case (r_state)
            S_ADD_WR: begin
                slot_we            = 1'b1;
                slot_wdata.id      = r_id;
                slot_wdata.side    = r_side;
                slot_wdata.price   = r_price;
                slot_wdata.rem     = r_qty;
                slot_wdata.kind    = r_type;
                slot_wdata.arrival = r_arrival;
            end
            S_MATCH_W1: begin
                slot_we        = 1'b1;
                slot_waddr     = bid_idx;
                slot_wdata.rem = bid_rem;
                tr_we          = 1'b1;
            end
            S_MATCH_W2: begin
                slot_we        = 1'b1;
                slot_waddr     = ask_idx;
                slot_wdata     = sres.best[1];
                slot_wdata.rem = ask_rem;
            end
            default: begin
            end
        endcase
    end

    // valid bit requests
    always_comb begin
        n_vset = 1'b0;
        n_vclr = 1'b0;
        n_vidx = r_idx;
        unique case (r_state)
            S_SCAN: begin
                // end of day drops good-for-day orders as the pass meets them
                n_vclr = (r_cmd == CMD_EOD) && r_dv && r_valid[r_idx] &&
                         (slot_rdata.kind == OT_GFD);
            end
            S_DECIDE: begin
                if (r_phase == PH_FIND) begin
                    n_vclr = sres.hit && (r_cmd == CMD_CANCEL || r_cmd == CMD_MODIFY);
                    n_vidx = hit_idx;
                end else if (r_phase == PH_MATCH) begin
                    // fill-and-kill remainder is cancelled once matching stops
                    n_vclr = !book_cross && (r_type == OT_FAK);
                    n_vidx = r_new_idx;
                end
            end
            S_ADD_WR: begin
                n_vset = 1'b1;
                n_vidx = r_new_idx;
            end
            S_MATCH_W1: begin
                n_vclr = (bid_rem == '0);
                n_vidx = bid_idx;
            end
            S_MATCH_W2: begin
                n_vclr = (ask_rem == '0);
                n_vidx = ask_idx;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_FIND;
            r_valid   <= '0;
            r_resting <= '0;
            r_arrival <= '0;
            r_dv      <= 1'b0;
            r_cnt     <= '0;
            r_ntr     <= '0;
            r_k       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (n_vset && !r_valid[n_vidx]) begin
                r_valid[n_vidx] <= 1'b1;
                r_resting       <= r_resting + 7'd1;
            end else if (n_vclr && r_valid[n_vidx]) begin
                r_valid[n_vidx] <= 1'b0;
                r_resting       <= r_resting - 7'd1;
            end

            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd    <= i_command;
                        r_id     <= i_order_id;
                        r_side   <= i_side;
                        r_price  <= i_price;
                        r_qty    <= i_quantity;
                        r_type   <= i_order_type;
                        r_status <= ST_OK;
                        r_ntr    <= '0;
                        r_k      <= '0;
                        r_phase  <= (i_command == CMD_ADD) ? PH_ADD : PH_FIND;
                        r_cnt    <= '0;
                        r_dv     <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // no read is issued on the last data cycle, so r_dv drops
                    r_dv <= slot_re;
                    r_idx <= slot_raddr;
                    if (slot_re) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (r_dv && r_idx == IW'(ORDER_SLOTS - 1)) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_cnt <= '0;
                    unique case (r_phase)
                        PH_FIND: begin
                            if (r_cmd == CMD_EOD) begin
                                r_state <= S_EMIT_RD;
                            end else if (!sres.hit) begin
                                r_status <= ST_UNKNOWN;
                                r_state  <= S_EMIT_RD;
                            end else if (r_cmd == CMD_MODIFY) begin
                                // re-add under the old order's type
                                r_type  <= sres.hit_kind;
                                r_phase <= PH_ADD;
                                r_state <= S_SCAN;
                            end else begin
                                r_state <= S_EMIT_RD;
                            end
                        end
                        PH_ADD: begin
                            if (sres.hit) begin
                                r_status <= ST_DUP;
                                r_state  <= S_EMIT_RD;
                            end else if (r_type == OT_MKT && !sres.w_any[opp]) begin
                                r_status <= ST_NOLIQ;
                                r_state  <= S_EMIT_RD;
                            end else if (eff_type == OT_FAK && !cross_ok) begin
                                r_status <= ST_NOTMKT;
                                r_state  <= S_EMIT_RD;
                            end else if (!sres.free_hit) begin
                                r_status <= ST_FULL;
                                r_state  <= S_EMIT_RD;
                            end else begin
                                r_price   <= eff_price;
                                r_type    <= eff_type;
                                r_new_idx <= free_idx;
                                r_state   <= S_ADD_WR;
                            end
                        end
                        default: begin
                            if (book_cross) begin
                                r_q <= (sres.best[0].rem < sres.best[1].rem) ?
                                       sres.best[0].rem : sres.best[1].rem;
                                r_state <= S_MATCH_W1;
                            end else begin
                                r_state <= S_EMIT_RD;
                            end
                        end
                    endcase
                end
                S_ADD_WR: begin
                    r_arrival <= r_arrival + 32'd1;
                    r_phase   <= PH_MATCH;
                    r_state   <= S_SCAN;
                end
                S_MATCH_W1: begin
                    r_ntr   <= r_ntr + CW'(1);
                    r_state <= S_MATCH_W2;
                end
                S_MATCH_W2: begin
                    r_state <= S_SCAN;
                end
                S_EMIT_RD: begin
                    r_state <= (r_k < r_ntr) ? S_EMIT_LD : S_EMIT_DONE;
                end
                S_EMIT_LD: begin
                    if (out_free) begin
                        r_o_kind    <= KIND_TRADE;
                        r_o_status  <= ST_OK;
                        r_o_tr      <= tr_rdata;
                        r_o_resting <= r_resting;
                        r_o_last    <= 1'b0;
                        r_k         <= r_k + CW'(1);
                        r_state     <= S_EMIT_RD;
                    end
                end
                S_EMIT_DONE: begin
                    if (out_free) begin
                        r_o_kind    <= KIND_DONE;
                        r_o_status  <= r_status;
                        r_o_tr      <= '0;
                        r_o_resting <= r_resting;
                        r_o_last    <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_kind           = r_o_kind;
    assign o_status         = r_o_status;
    assign o_bid_order_id   = r_o_tr.bid_id;
    assign o_ask_order_id   = r_o_tr.ask_id;
    assign o_bid_price      = r_o_tr.bid_price;
    assign o_ask_price      = r_o_tr.ask_price;
    assign o_trade_quantity = r_o_tr.qty;
    assign o_resting_orders = r_o_resting;
    assign o_last           = r_o_last;

`ifndef SYNTHESIS
    a_resting_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_resting == 7'($countones(r_valid)))
        else $error("resting count out of step with valid bits");
    a_trade_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ntr <= CW'(ORDER_SLOTS))
        else $error("trade buffer overrun");
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(slot_we && slot_re))
        else $error("slot write during scan");
    a_trade_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_TRADE) |-> (o_status == ST_OK && !o_last))
        else $error("bad trade record");
`endif

endmodule

### bench/order_book_matcher_tb.sv
// order_book_matcher_tb: self-checking bench for the order book matcher.
// Depends on obm_pkg and the order_book_matcher RTL; nothing else.
`timescale 1ns / 1ps

module order_book_matcher_tb;
    import obm_pkg::*;

    localparam int SLOTS      = 64;
    localparam int ID_POOL    = 20;
    localparam int RAND_ITEMS = 320;
    localparam int IDLE_LIMIT = 40000;   // cycles with no transaction on either side
    localparam int DRAIN_WAIT = 300;     // covers one full add with a pass and a few fills

    typedef struct {
        logic [1:0]         cmd;
        logic [63:0]        id;
        logic               side;
        logic signed [31:0] price;
        logic [31:0]        qty;
        logic [1:0]         otype;
    } t_order_cmd;

    typedef struct {
        logic               kind;
        logic [2:0]         status;
        logic [63:0]        bid_id;
        logic [63:0]        ask_id;
        logic signed [31:0] bid_price;
        logic signed [31:0] ask_price;
        logic [31:0]        qty;
        logic [6:0]         resting;
        logic               last;
    } t_book_result;

    // Book mirror plus the queue of results it predicts.
    class book_scoreboard;
        bit                 live [SLOTS];
        logic [63:0]        s_id [SLOTS];
        logic               s_side [SLOTS];
        logic signed [31:0] s_price [SLOTS];
        logic [31:0]        s_rem [SLOTS];
        logic [1:0]         s_type [SLOTS];
        logic [31:0]        s_arr [SLOTS];
        logic [31:0]        arr_cnt;
        t_book_result       due_q[$];
        t_book_result       burst[$];
        int                 errors;
        int                 trades;
        int                 cmds;

        function new();
            foreach (live[i]) live[i] = 0;
            arr_cnt = 0;
            errors  = 0;
            trades  = 0;
            cmds    = 0;
        endfunction

        function int find_id(logic [63:0] id);
            foreach (live[i])
                if (live[i] && s_id[i] == id) return i;
            return -1;
        endfunction

        // best of a side: bids highest, asks lowest; ties to the oldest by wrapped age
        function int best_of(logic side);
            int b;
            logic [31:0] age_i, age_b;
            b = -1;
            foreach (live[i]) begin
                if (!live[i] || s_side[i] != side) continue;
                if (b < 0) begin
                    b = i;
                    continue;
                end
                if (s_price[i] != s_price[b]) begin
                    if (side == SIDE_BUY ? s_price[i] > s_price[b] : s_price[i] < s_price[b])
                        b = i;
                end else begin
                    age_i = arr_cnt - s_arr[i];
                    age_b = arr_cnt - s_arr[b];
                    if (age_i > age_b) b = i;
                end
            end
            return b;
        endfunction

        function void put(logic kind, logic [2:0] st, logic [63:0] bid, logic [63:0] ask,
                          logic signed [31:0] bp, logic signed [31:0] ap, logic [31:0] q);
            t_book_result r;
            r.kind = kind; r.status = st; r.bid_id = bid; r.ask_id = ask;
            r.bid_price = bp; r.ask_price = ap; r.qty = q; r.resting = 0; r.last = 0;
            burst = {burst, r};
        endfunction

        function void cross_book();
            int b, a;
            logic [31:0] q;
            forever begin
                b = best_of(SIDE_BUY);
                a = best_of(SIDE_SELL);
                if (b < 0 || a < 0 || s_price[b] < s_price[a]) break;
                q = s_rem[b] < s_rem[a] ? s_rem[b] : s_rem[a];
                s_rem[b] -= q;
                s_rem[a] -= q;
                put(KIND_TRADE, ST_OK, s_id[b], s_id[a], s_price[b], s_price[a], q);
                if (s_rem[b] == 0) live[b] = 0;
                if (s_rem[a] == 0) live[a] = 0;
            end
        endfunction

        function logic [2:0] place(logic [63:0] id, logic side, logic signed [31:0] price,
                                   logic [31:0] qty, logic [1:0] otype);
            int f, opp;
            bit any;
            f = -1;
            any = 0;
            if (find_id(id) >= 0) return ST_DUP;
            if (otype == OT_MKT) begin
                // market buys take the highest ask, market sells the lowest bid
                foreach (live[i]) begin
                    if (!live[i] || s_side[i] == side) continue;
                    if (!any || (side == SIDE_BUY ? s_price[i] > price : s_price[i] < price))
                        price = s_price[i];
                    any = 1;
                end
                if (!any) return ST_NOLIQ;
                otype = OT_GTC;
            end
            if (otype == OT_FAK) begin
                opp = best_of(~side);
                if (opp < 0) return ST_NOTMKT;
                if (side == SIDE_BUY ? price < s_price[opp] : price > s_price[opp])
                    return ST_NOTMKT;
            end
            foreach (live[i])
                if (!live[i]) begin
                    f = i;
                    break;
                end
            if (f < 0) return ST_FULL;
            live[f] = 1; s_id[f] = id; s_side[f] = side; s_price[f] = price;
            s_rem[f] = qty; s_type[f] = otype; s_arr[f] = arr_cnt;
            arr_cnt++;
            cross_book();
            if (otype == OT_FAK) live[f] = 0;
            return ST_OK;
        endfunction

        // accepted command: update the mirror and queue its results
        function void note_command(t_order_cmd c);
            logic [2:0] st;
            logic [1:0] old_type;
            int f, n;
            st = ST_OK;
            n = 0;
            burst.delete();
            cmds++;
            case (c.cmd)
                CMD_ADD: st = place(c.id, c.side, c.price, c.qty, c.otype);
                CMD_CANCEL: begin
                    f = find_id(c.id);
                    if (f < 0) st = ST_UNKNOWN;
                    else live[f] = 0;
                end
                CMD_MODIFY: begin
                    f = find_id(c.id);
                    if (f < 0) begin
                        st = ST_UNKNOWN;
                    end else begin
                        old_type = s_type[f];
                        live[f] = 0;
                        st = place(c.id, c.side, c.price, c.qty, old_type);
                    end
                end
                default: begin
                    foreach (live[i])
                        if (live[i] && s_type[i] == OT_GFD) live[i] = 0;
                end
            endcase
            put(KIND_DONE, st, '0, '0, '0, '0, '0);
            foreach (live[i]) n += live[i];
            foreach (burst[k]) begin
                burst[k].resting = n[6:0];
                burst[k].last = (k == burst.size() - 1);
                due_q = {due_q, burst[k]};
            end
        endfunction

        function void check_result(t_book_result r);
            t_book_result e;
            if (due_q.size() == 0) begin
                $error("result with nothing expected: kind %0d status %0d", r.kind, r.status);
                errors++;
                return;
            end
            e = due_q[0];
            due_q.delete(0);
            if (r.kind == KIND_TRADE) trades++;
            if (r.kind !== e.kind) begin
                $error("kind: expected %0d, got %0d", e.kind, r.kind); errors++;
            end
            if (r.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, r.status); errors++;
            end
            if (r.bid_id !== e.bid_id) begin
                $error("bid_order_id: expected %h, got %h", e.bid_id, r.bid_id); errors++;
            end
            if (r.ask_id !== e.ask_id) begin
                $error("ask_order_id: expected %h, got %h", e.ask_id, r.ask_id); errors++;
            end
            if (r.bid_price !== e.bid_price) begin
                $error("bid_price: expected %0d, got %0d", e.bid_price, r.bid_price); errors++;
            end
            if (r.ask_price !== e.ask_price) begin
                $error("ask_price: expected %0d, got %0d", e.ask_price, r.ask_price); errors++;
            end
            if (r.qty !== e.qty) begin
                $error("trade_quantity: expected %0d, got %0d", e.qty, r.qty); errors++;
            end
            if (r.resting !== e.resting) begin
                $error("resting_orders: expected %0d, got %0d", e.resting, r.resting);
                errors++;
            end
            if (r.last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, r.last); errors++;
            end
        endfunction

        function bit busy();
            return due_q.size() != 0;
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_stall;
    logic [1:0]         i_command = CMD_EOD;
    logic [63:0]        i_order_id = 0;
    logic               i_side = SIDE_BUY;
    logic signed [31:0] i_price = 0;
    logic [31:0]        i_quantity = 0;
    logic [1:0]         i_order_type = OT_GTC;
    logic               o_valid;
    logic               i_stall = 0;
    logic               o_kind;
    logic [2:0]         o_status;
    logic [63:0]        o_bid_order_id;
    logic [63:0]        o_ask_order_id;
    logic signed [31:0] o_bid_price;
    logic signed [31:0] o_ask_price;
    logic [31:0]        o_trade_quantity;
    logic [6:0]         o_resting_orders;
    logic               o_last;

    order_book_matcher #(.ORDER_SLOTS(SLOTS)) u_dut (.*);

    always #5 i_clk = ~i_clk;

    book_scoreboard sb = new();
    logic [63:0] id_pool [ID_POOL];
    int          idle_cycles = 0;
    int          stall_left = 0;

    // Result side: check at the edge, then pick the next stall state.
    always @(posedge i_clk) begin
        t_book_result r;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                r.kind = o_kind; r.status = o_status; r.bid_id = o_bid_order_id;
                r.ask_id = o_ask_order_id; r.bid_price = o_bid_price;
                r.ask_price = o_ask_price; r.qty = o_trade_quantity;
                r.resting = o_resting_orders; r.last = o_last;
                sb.check_result(r);
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall <= 1;
            end else if ($urandom_range(99) < 20) begin
                // mostly short stalls, now and then a long one
                stall_left <= ($urandom_range(99) < 10) ? $urandom_range(60, 20)
                                                        : $urandom_range(3);
                i_stall <= 1;
            end else begin
                i_stall <= 0;
            end
        end
    end

    // Watchdog: no transaction on either side for too long ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drive one command and hold it until the block takes it.
    task automatic send(logic [1:0] cmd, logic [63:0] id, logic side,
                        logic signed [31:0] price, logic [31:0] qty, logic [1:0] otype);
        t_order_cmd c;
        c.cmd = cmd; c.id = id; c.side = side; c.price = price; c.qty = qty; c.otype = otype;
        i_valid <= 1;
        i_command <= cmd; i_order_id <= id; i_side <= side;
        i_price <= price; i_quantity <= qty; i_order_type <= otype;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_command(c);
    endtask

    task automatic sender_gap();
        int n;
        n = $urandom_range(99);
        if (n < 60) return;
        n = (n < 94) ? $urandom_range(4, 1) : $urandom_range(120, 20);
        i_valid <= 0;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold off until every expected result is in and the block has gone quiet.
    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (sb.busy()) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic random_command();
        logic [1:0]         cmd;
        logic signed [31:0] price;
        logic [31:0]        qty;
        int                 r;
        r = $urandom_range(99);
        cmd = r < 60 ? CMD_ADD : r < 78 ? CMD_CANCEL : r < 95 ? CMD_MODIFY : CMD_EOD;
        // prices cluster so that orders cross; a few span the full range
        price = ($urandom_range(99) < 6) ? $urandom() : 32'sd1000 + $urandom_range(16) - 8;
        r = $urandom_range(99);
        qty = r < 5 ? 32'd0 : r < 10 ? $urandom() : $urandom_range(20, 1);
        send(cmd, id_pool[$urandom_range(ID_POOL - 1)], 1'($urandom_range(1)), price, qty,
             2'($urandom_range(3)));
    endtask

    initial begin
        logic [63:0] held [$];
        foreach (id_pool[i]) id_pool[i] = {$urandom(), $urandom()};
        id_pool[0] = '0;
        id_pool[1] = '1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: rejects, fills, market pricing, modify, end of day, extremes.
        send(CMD_ADD, 64'd0, SIDE_BUY, 32'sd100, 32'd10, OT_GTC);
        send(CMD_ADD, 64'd0, SIDE_SELL, 32'sd90, 32'd5, OT_GTC);          // duplicate
        send(CMD_ADD, 64'd7, SIDE_BUY, 32'sd0, 32'd5, OT_MKT);            // no asks
        send(CMD_ADD, 64'd8, SIDE_SELL, 32'sd200, 32'd5, OT_FAK);         // cannot cross
        send(CMD_ADD, '1, SIDE_SELL, 32'sd100, 32'd4, OT_GFD);            // partial fill
        send(CMD_ADD, 64'd9, SIDE_SELL, 32'sd95, 32'd0, OT_GFD);          // zero quantity
        send(CMD_ADD, 64'd10, SIDE_SELL, 32'sd0, 32'd3, OT_MKT);          // lowest bid
        send(CMD_ADD, 64'd11, SIDE_SELL, 32'h7fffffff, '1, OT_GFD);
        send(CMD_ADD, 64'd12, SIDE_BUY, 32'sh80000000, '1, OT_GTC);
        send(CMD_ADD, 64'd13, SIDE_BUY, 32'sd0, 32'd2, OT_MKT);           // highest ask
        send(CMD_ADD, 64'd14, SIDE_BUY, 32'sd50, 32'd1, OT_FAK);          // crosses nothing
        send(CMD_CANCEL, 64'd99, SIDE_BUY, 0, 0, OT_GTC);
        send(CMD_MODIFY, 64'd99, SIDE_BUY, 0, 0, OT_GTC);
        send(CMD_MODIFY, 64'd12, SIDE_BUY, 32'sd5, 32'd6, OT_FAK);        // keeps old type
        send(CMD_MODIFY, 64'd11, SIDE_SELL, 32'sd5, 32'd1, OT_GTC);       // crosses on re-add
        send(CMD_CANCEL, 64'd12, SIDE_BUY, 0, 0, OT_GTC);
        send(CMD_ADD, 64'd15, SIDE_BUY, 32'sd1, 32'd1, OT_GFD);
        send(CMD_EOD, '0, SIDE_BUY, 0, 0, OT_GTC);

        // Table full, then one market sell that sweeps every other slot.
        drain();
        foreach (sb.live[i]) if (sb.live[i]) held = {held, sb.s_id[i]};
        foreach (held[k]) send(CMD_CANCEL, held[k], SIDE_BUY, 0, 0, OT_GTC);
        for (int k = 0; k <= SLOTS; k++)
            send(CMD_ADD, 64'h1000 + k, SIDE_BUY, -32'sd7, 32'd1, OT_GTC);
        send(CMD_CANCEL, 64'h1000, SIDE_BUY, 0, 0, OT_GTC);
        send(CMD_ADD, 64'h2000, SIDE_SELL, 0, '1, OT_MKT);
        send(CMD_CANCEL, 64'h2000, SIDE_BUY, 0, 0, OT_GTC);
        drain();

        // Random traffic over a small pool of ids.
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k == RAND_ITEMS / 2) drain();
            sender_gap();
            random_command();
        end
        drain();

        $display("commands: %0d, trades checked: %0d, incl. full-table sweep", sb.cmds,
                 sb.trades);
        if (sb.busy()) begin
            $error("%0d results never arrived", sb.due_q.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
